>>> rtl/fhc_pkg.sv
package fhc_pkg;

    localparam int unsigned ValueWidth = 32;
    localparam logic       ModeS2H    = 1'b0;
    localparam logic       ModeH2S    = 1'b1;

    typedef struct packed {
        logic                  mode;
        logic [ValueWidth-1:0] value;
    } t_req;

    // Convert binary32 to binary16, round to nearest even.
    function automatic logic [15:0] s2h(input logic [31:0] w);
        logic        sgn;
        logic [7:0]  e8;
        logic [22:0] f23;
        logic [8:0]  ne;
        logic [23:0] mant;
        logic [4:0]  shift;
        logic [23:0] h;
        logic [23:0] low;
        logic [23:0] half;
        logic [15:0] hn;
        logic [15:0] res;
        sgn  = w[31];
        e8   = w[30:23];
        f23  = w[22:0];
        ne   = {1'b0, e8} - 9'd112;
        mant = {1'b1, f23};
        shift = 5'd0;
        h = '0;
        low = '0;
        half = '0;
        hn = '0;
        if (e8 == 8'd0) begin
            res = {sgn, 15'd0};
        end else if (e8 == 8'hff) begin
            res = {sgn, 5'h1f, (f23 != 23'd0) ? 10'h3ff : 10'h000};
        end else if (e8 >= 8'd143) begin
            res = {sgn, 5'h1f, 10'h000};
        end else if (e8 <= 8'd112) begin
            // subnormal: shift = 14 - ne = 126 - e8
            if (e8 < 8'd102) begin
                res = {sgn, 15'd0};
            end else begin
                shift = 5'(8'd126 - e8);
                h    = mant >> shift;
                low  = mant & ((24'd1 << shift) - 24'd1);
                half = 24'd1 << (shift - 5'd1);
                if (((low & half) != 24'd0) && ((low > half) || h[0]))
                    h = h + 24'd1;
                res = {sgn, h[14:0]};
            end
        end else begin
            hn = {1'b0, ne[4:0], f23[22:13]};
            if (f23[12] && ((f23[12:0] > 13'h1000) || hn[0]))
                hn = hn + 16'd1;
            res = {sgn, hn[14:0]};
        end
        return res;
    endfunction

    // Convert binary16 to binary32 exactly.
    function automatic logic [31:0] h2s(input logic [15:0] v);
        logic       sgn;
        logic [4:0] e5;
        logic [9:0] f10;
        logic [3:0] lz;
        logic [10:0] m;
        logic [31:0] res;
        sgn = v[15];
        e5  = v[14:10];
        f10 = v[9:0];
        lz  = 4'd0;
        m   = {1'b0, f10};
        for (int i = 9; i >= 0; i--) begin
            if (f10[i] && lz == 4'd0 && (f10 >> (i + 1)) == 10'd0)
                lz = 4'(10 - i);
        end
        if (e5 == 5'h1f) begin
            res = {sgn, 8'hff, (f10 != 10'd0) ? 23'h7fffff : 23'd0};
        end else if (e5 != 5'd0) begin
            res = {sgn, 8'({3'd0, e5} + 8'd112), f10, 13'd0};
        end else if (f10 == 10'd0) begin
            res = {sgn, 31'd0};
        end else begin
            m   = m << lz;
            res = {sgn, 8'(8'd113 - {4'd0, lz}), m[9:0], 13'd0};
        end
        return res;
    endfunction

endpackage

>>> rtl/fhc_if.sv
interface fhc_if #(parameter int unsigned W = 33);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/fhc_core.sv
module fhc_core
    import fhc_pkg::*;
(
    input  logic        i_mode,
    input  logic [31:0] i_value,
    output logic [31:0] o_result
);
    // select conversion direction
    always_comb begin
        if (i_mode == ModeH2S)
            o_result = h2s(i_value[15:0]);
        else
            o_result = {16'd0, s2h(i_value)};
    end
endmodule

>>> rtl/float_half_converter_unit.sv
// Float/half converter.
// Input channel i_in carries {mode, value}: mode 0 turns a binary32 word
// into a binary16 in the low 16 bits, mode 1 turns the low 16 bits of
// value from binary16 into a binary32 word. Output channel o_out carries
// the 32-bit result. Both use valid/ready; a transfer happens when both
// are high at a rising edge of i_clk.
// The path is input register, conversion logic, result register; the
// result is valid once its item has moved from the input register into
// the result register. Throughput: one item per cycle while the receiver
// is not stalled, set by the single conversion stage between them.
// When the receiver stalls, the result register holds and the input
// register keeps its item; input ready drops only when both are full and
// the receiver stalls.
// Reset (i_rst_n low, synchronous) empties both stages.
module float_half_converter_unit
    import fhc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    fhc_if.sink   i_in,
    fhc_if.source o_out
);
    logic        r_in_vld, r_out_vld;
    logic        r_mode;
    logic [31:0] r_value, r_result, n_result;
    logic        adv, take;

    assign adv  = !r_out_vld || o_out.ready;
    assign take = !r_in_vld || adv;
    assign i_in.ready = take;

    fhc_core u_core (.i_mode(r_mode), .i_value(r_value), .o_result(n_result));

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (take) begin
            r_in_vld <= i_in.valid;
        end
        if (take && i_in.valid) begin
            r_mode  <= i_in.data[32];
            r_value <= i_in.data[31:0];
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_in_vld;
        end
        if (adv && r_in_vld) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_result;

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !o_out.ready |=> r_out_vld && $stable(r_result))
        else $error("result lost under stall");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && adv |=> r_out_vld)
        else $error("item dropped between stages");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_vld |-> i_in.ready)
        else $error("ready low with empty output");
`endif
endmodule
